>>> hdl/nsf_pkg.sv
// Package for the NMEA sentence framer: phase and status codes, result record,
// character constants and the hex digit decoder. No dependencies.
`default_nettype none

package nsf_pkg;

  localparam int MAX_SENTENCE_DEF = 80;
  localparam int LEN_W            = 7;
  localparam int CHAR_W           = 8;
  localparam int IN_TDATA_W       = 16;
  localparam int OUT_TDATA_W      = 24;

  localparam logic [LEN_W-1:0]  MIN_LENGTH_RST = 7'd7;

  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_PR_LO  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PR_HI  = 8'h7E;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DATA,
    PH_SUM,
    PH_END
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_OK,
    ST_BADSUM,
    ST_SHORT,
    ST_ABORT
  } status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [LEN_W-1:0]  sentence_length;
    status_t           status;
  } res_t;

  // Hex digit value; anything that is not a hex digit counts as zero
  function automatic logic [3:0] hex_value(input logic [CHAR_W-1:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) v = 4'(b - 8'h30);
    else if (b >= 8'h41 && b <= 8'h46) v = 4'(b - 8'h41 + 8'd10);
    else if (b >= 8'h61 && b <= 8'h66) v = 4'(b - 8'h61 + 8'd10);
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/nmea_sentence_framer.sv
// NMEA 0183 sentence framer: frames sentences from received bytes, checks the
// XOR checksum and serves reads of the stored characters.
// Depends on nsf_pkg, nsf_ram and nsf_out_fifo.
// A result is registered in stage 1, then written into the result queue.
// Throughput: one item per cycle with queue room, set by the single write and read port.
// Reset: phase, count, checksum and queue clear; the store is undefined until written.
`default_nettype none

module nmea_sentence_framer #(
  parameter int MAX_SENTENCE = nsf_pkg::MAX_SENTENCE_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration: min_length
  input  wire logic                               cfg_wr_en,
  input  wire logic [nsf_pkg::LEN_W-1:0]          cfg_wr_data,
  // input channel
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [nsf_pkg::IN_TDATA_W-1:0]     in_tdata,   // rx_byte[7:0], read_index[14:8]
  input  wire logic                               in_tuser,   // cmd: 0 receive, 1 read
  // result channel
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [nsf_pkg::OUT_TDATA_W-1:0]         out_tdata   // status[2:0],
                                                              // sentence_length[9:3],
                                                              // read_char[17:10]
);
  import nsf_pkg::*;

  localparam int AW = $clog2(MAX_SENTENCE);
  localparam int CW = $clog2(MAX_SENTENCE + 1);

  // Input field extraction
  logic              cmd;
  logic [CHAR_W-1:0] rx_byte;
  logic [LEN_W-1:0]  read_index;

  assign cmd        = in_tuser;
  assign rx_byte    = in_tdata[7:0];
  assign read_index = in_tdata[14:8];

  // Configuration register
  logic [LEN_W-1:0] min_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= MIN_LENGTH_RST;
    end else if (cfg_wr_en) begin
      min_length_r <= cfg_wr_data;
    end
  end

  // Framing state
  phase_t         phase_r, phase_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [7:0]     xor_r, xor_nxt;
  logic           tog_r, tog_nxt;

  logic           in_fire, rx_fire, rd_fire;
  logic           is_dollar, printable, room, crlf_ok;
  logic [3:0]     hex;

  assign in_fire   = in_tvalid && in_tready;
  assign rx_fire   = in_fire && !cmd;
  assign rd_fire   = in_fire && cmd;

  assign is_dollar = (rx_byte == CH_DOLLAR);
  assign printable = (rx_byte >= CH_PR_LO) && (rx_byte <= CH_PR_HI);
  assign room      = (32'(count_r) < 32'(MAX_SENTENCE));
  assign crlf_ok   = (rx_byte == (tog_r ? CH_LF : CH_CR));
  assign hex       = hex_value(rx_byte);

  // Phase transitions
  always_comb begin
    phase_nxt = phase_r;
    if (rx_fire) begin
      if (is_dollar) begin
        phase_nxt = PH_DATA;
      end else begin
        unique case (phase_r)
          PH_IDLE: phase_nxt = PH_IDLE;
          PH_DATA: begin
            if (rx_byte == CH_STAR) phase_nxt = PH_SUM;
            else if (!(room && printable)) phase_nxt = PH_IDLE;
          end
          PH_SUM: begin
            if (tog_r) phase_nxt = PH_END;
          end
          PH_END: begin
            if (!crlf_ok || tog_r) phase_nxt = PH_IDLE;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // Datapath updates, store write and status
  status_t       status;
  logic          st_wr_en;

  always_comb begin
    count_nxt = count_r;
    xor_nxt   = xor_r;
    tog_nxt   = tog_r;
    status    = ST_NONE;
    st_wr_en  = 1'b0;
    if (rx_fire) begin
      if (is_dollar) begin
        count_nxt = '0;
        xor_nxt   = 8'd0;
        tog_nxt   = 1'b0;
      end else begin
        unique case (phase_r)
          PH_IDLE: status = ST_NONE;
          PH_DATA: begin
            if (rx_byte == CH_STAR) begin
              status = ST_NONE;
            end else if (room && printable) begin
              st_wr_en  = 1'b1;
              count_nxt = count_r + CW'(1);
              xor_nxt   = xor_r ^ rx_byte;
            end else begin
              status = ST_ABORT;
            end
          end
          PH_SUM: begin
            tog_nxt = !tog_r;
            // high nibble first
            if (!tog_r) xor_nxt = xor_r ^ {hex, 4'd0};
            else        xor_nxt = xor_r ^ {4'd0, hex};
          end
          PH_END: begin
            if (!crlf_ok) begin
              status = ST_ABORT;
            end else begin
              tog_nxt = !tog_r;
              if (tog_r) begin
                if (xor_r != 8'd0) status = ST_BADSUM;
                else if (32'(count_r) < 32'(min_length_r)) status = ST_SHORT;
                else status = ST_OK;
              end
            end
          end
          default: status = ST_NONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      count_r <= '0;
      xor_r   <= 8'd0;
      tog_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
      tog_r   <= tog_nxt;
    end
  end

  // Sentence store: write at the fill position, read for read commands
  logic [CHAR_W-1:0] rd_data;
  logic              in_range;

  assign in_range = (32'(read_index) < 32'(MAX_SENTENCE));

  nsf_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_SENTENCE)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (rx_byte),
    .rd_en   (rd_fire),
    .rd_addr (AW'(read_index)),
    .rd_data (rd_data)
  );

  // Stage 1: hold the result while the store read completes
  logic             s1_valid_r;
  status_t          s1_status_r;
  logic [LEN_W-1:0] s1_len_r;
  logic             s1_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= status;
      s1_len_r    <= LEN_W'(count_nxt);
      s1_rd_r     <= cmd && in_range;
    end
  end

  // Result queue parts the two sides; take a new transfer while room is left
  res_t       s1_res, head;
  logic       q_not_empty;
  logic [1:0] q_level;

  always_comb begin
    s1_res.status          = s1_status_r;
    s1_res.sentence_length = s1_len_r;
    s1_res.read_char       = s1_rd_r ? rd_data : '0;
  end

  nsf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (s1_res),
    .pop       (out_tvalid && out_tready),
    .head      (head),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  assign in_tready  = ({1'b0, q_level} + {2'b00, s1_valid_r}) <= 3'd2;
  assign out_tvalid = q_not_empty;
  assign out_tdata  = {(OUT_TDATA_W - $bits(res_t))'(0), head};

endmodule

`default_nettype wire

>>> hdl/nsf_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module nsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/nsf_out_fifo.sv
// Three-entry result queue in front of the output channel.
// Depends on nsf_pkg for the result record.
`default_nettype none

module nsf_out_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire nsf_pkg::res_t push_data,
  input  wire logic          pop,
  output nsf_pkg::res_t      head,
  output logic               not_empty,
  output logic [1:0]         level
);
  import nsf_pkg::*;

  localparam logic [1:0] LAST = 2'd2;

  res_t       ent_r [3];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    if (push && !pop) level_nxt = level_r + 2'd1;
    else if (pop && !push) level_nxt = level_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      level_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign head      = ent_r[rd_ptr_r];
  assign not_empty = (level_r != 2'd0);
  assign level     = level_r;

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for nmea_sentence_framer: opening script, then random sentence traffic.
// Depends on nsf_pkg for codes, character constants and the result record; needs only the RTL.
module testbench;
  import nsf_pkg::*;

  localparam int MAX_SENTENCE = MAX_SENTENCE_DEF;
  localparam int LONG_HOLD    = 48;    // receiver hold-off, long enough to fill the block
  localparam int STALL_LIMIT  = 1000;  // cycles with no transfer on either side
  localparam int PHASE_ITEMS  = 100;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [LEN_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;   // rx_byte[7:0], read_index[14:8]
  logic                   in_tuser    = 1'b0; // cmd: 0 receive, 1 read
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;          // status[2:0], sentence_length[9:3],
                                              // read_char[17:10]

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nmea_sentence_framer #(
    .MAX_SENTENCE (MAX_SENTENCE)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // Shared run state
  // ---------------------------------------------------------------------------
  typedef struct {
    logic       cmd;
    logic [7:0] rx;
    logic [6:0] idx;
    logic       pick;   // choose the read index at the moment of offering
  } framer_item_t;

  // One row of the opening script; the result is typed in where it is obvious
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx;
    logic [6:0] idx;
    logic       typed;
    res_t       want;
  } script_row_t;

  localparam res_t NOT_TYPED = '0;

  localparam script_row_t OPENING_SCRIPT [27] = '{
    '{1'b0, 8'h00,     7'd0,   1'b1, '{8'h00, 7'd0, ST_NONE}},    // byte while idle: ignored
    '{1'b1, 8'h00,     7'd127, 1'b1, '{8'h00, 7'd0, ST_NONE}},    // read past the store: zero
    '{1'b0, CH_DOLLAR, 7'd0,   1'b1, '{8'h00, 7'd0, ST_NONE}},
    '{1'b0, CH_PR_HI,  7'd0,   1'b0, NOT_TYPED},                  // highest printable
    '{1'b0, CH_PR_LO,  7'd0,   1'b0, NOT_TYPED},                  // lowest printable
    '{1'b0, CH_STAR,   7'd0,   1'b0, NOT_TYPED},
    '{1'b0, 8'h35,     7'd0,   1'b0, NOT_TYPED},                  // '5'
    '{1'b0, 8'h65,     7'd0,   1'b0, NOT_TYPED},                  // 'e', lower-case digit
    '{1'b0, CH_CR,     7'd0,   1'b0, NOT_TYPED},
    '{1'b0, CH_LF,     7'd0,   1'b1, '{8'h00, 7'd2, ST_SHORT}},   // good sum, two characters
    '{1'b1, 8'h00,     7'd0,   1'b1, '{CH_PR_HI, 7'd2, ST_NONE}},
    '{1'b1, 8'hFF,     7'd1,   1'b1, '{CH_PR_LO, 7'd2, ST_NONE}},
    '{1'b0, CH_DOLLAR, 7'd0,   1'b0, NOT_TYPED},
    '{1'b0, 8'hFF,     7'd0,   1'b1, '{8'h00, 7'd0, ST_ABORT}},   // bad data character
    '{1'b0, CH_DOLLAR, 7'd0,   1'b0, NOT_TYPED},
    '{1'b0, 8'h42,     7'd0,   1'b0, NOT_TYPED},                  // 'B'
    '{1'b0, CH_STAR,   7'd0,   1'b0, NOT_TYPED},
    '{1'b0, 8'h47,     7'd0,   1'b0, NOT_TYPED},                  // 'G' counts as zero
    '{1'b0, 8'h47,     7'd0,   1'b0, NOT_TYPED},
    '{1'b0, CH_CR,     7'd0,   1'b0, NOT_TYPED},
    '{1'b0, CH_LF,     7'd0,   1'b1, '{8'h00, 7'd1, ST_BADSUM}},  // bad sum wins over short
    '{1'b0, CH_DOLLAR, 7'd0,   1'b0, NOT_TYPED},
    '{1'b0, 8'h41,     7'd0,   1'b0, NOT_TYPED},                  // 'A'
    '{1'b0, CH_STAR,   7'd0,   1'b0, NOT_TYPED},
    '{1'b0, 8'h34,     7'd0,   1'b0, NOT_TYPED},                  // '4'
    '{1'b0, 8'h31,     7'd0,   1'b0, NOT_TYPED},                  // '1'
    '{1'b0, 8'h58,     7'd0,   1'b1, '{8'h00, 7'd1, ST_ABORT}}    // 'X' where CR belongs
  };

  framer_item_t traffic[$];
  res_t         expected_results[$];

  logic src_idle_on  = 1'b1;
  logic sink_idle_on = 1'b1;
  logic hold_request = 1'b0;

  int error_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int status_seen [0:7];
  int stall_cycles    = 0;

  // ---------------------------------------------------------------------------
  // Framer predictor: its own copy of the register and of the framing state
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] frame_min    = MIN_LENGTH_RST;
  phase_t           frame_phase  = PH_IDLE;
  logic [7:0]       frame_store [MAX_SENTENCE];
  logic [6:0]       frame_count  = '0;
  logic [7:0]       frame_xor    = '0;
  logic             frame_toggle = 1'b0;
  logic [MAX_SENTENCE-1:0] stored_mask = '0;  // entries written since reset

  function automatic logic [3:0] digit_value(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return 4'(b - 8'h30);
    if (b >= 8'h41 && b <= 8'h46) return 4'(b - 8'h37);
    if (b >= 8'h61 && b <= 8'h66) return 4'(b - 8'h57);
    return 4'd0;
  endfunction

  // Advance the framing state by one transfer and work out its result
  task automatic predict_framer(input logic cmd, input logic [7:0] b, input logic [6:0] idx,
                                output res_t r);
    status_t    st;
    logic [7:0] ch;
    st = ST_NONE;
    ch = '0;
    if (cmd) begin
      if (idx < MAX_SENTENCE) ch = frame_store[idx];
    end else if (b == CH_DOLLAR) begin
      frame_phase  = PH_DATA;
      frame_count  = '0;
      frame_xor    = '0;
      frame_toggle = 1'b0;
    end else begin
      case (frame_phase)
        PH_DATA: begin
          if (b == CH_STAR) begin
            frame_phase = PH_SUM;
          end else if (frame_count < MAX_SENTENCE && b >= CH_PR_LO && b <= CH_PR_HI) begin
            frame_store[frame_count] = b;
            stored_mask[frame_count] = 1'b1;
            frame_count = frame_count + 7'd1;
            frame_xor   = frame_xor ^ b;
          end else begin
            frame_phase = PH_IDLE;
            st = ST_ABORT;
          end
        end
        PH_SUM: begin
          frame_toggle = ~frame_toggle;
          if (frame_toggle) begin
            frame_xor = frame_xor ^ {digit_value(b), 4'h0};
          end else begin
            frame_xor   = frame_xor ^ {4'h0, digit_value(b)};
            frame_phase = PH_END;
          end
        end
        PH_END: begin
          if (b == (frame_toggle ? CH_LF : CH_CR)) begin
            frame_toggle = ~frame_toggle;
            if (!frame_toggle) begin
              frame_phase = PH_IDLE;
              if (frame_xor != 8'h00) st = ST_BADSUM;
              else if (frame_count < frame_min) st = ST_SHORT;
              else st = ST_OK;
            end
          end else begin
            frame_phase = PH_IDLE;
            st = ST_ABORT;
          end
        end
        default: ;
      endcase
    end
    r.status          = st;
    r.sentence_length = frame_count;
    r.read_char       = ch;
  endtask

  // ---------------------------------------------------------------------------
  // Traffic generation
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b);
    traffic.push_back('{1'b0, b, 7'd0, 1'b0});
  endtask

  // The index of a read is filled in when it is offered; its rx_byte is random
  task automatic push_read();
    traffic.push_back('{1'b1, 8'($urandom_range(0, 255)), 7'd0, 1'b1});
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // Only written entries, or indexes past the store, may be read
  function automatic logic [6:0] pick_read_index();
    int written[$];
    int k;
    for (k = 0; k < MAX_SENTENCE; k++)
      if (stored_mask[k]) written.push_back(k);
    if (written.size() == 0 || $urandom_range(0, 4) == 0)
      return 7'($urandom_range(MAX_SENTENCE, 127));
    return 7'(written[$urandom_range(0, written.size() - 1)]);
  endfunction

  // Mostly well-formed sentences with random content; the rest is noise, stray reads,
  // overflows, restarts, wrong sums, non-hex digits and broken line ends
  task automatic queue_traffic(input int n_items);
    int         goal;
    int         len;
    int         k;
    int         pick;
    logic [7:0] sum;
    logic [7:0] c;
    goal = traffic.size() + n_items;
    while (traffic.size() < goal) begin
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        repeat ($urandom_range(1, 3)) push_read();
      end else begin
        if ($urandom_range(0, 11) == 0)
          len = ($urandom_range(0, 2) == 0) ? MAX_SENTENCE : $urandom_range(76, 84);
        else
          len = $urandom_range(0, 12);
        sum = '0;
        push_byte(CH_DOLLAR);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 24) == 0) push_read();
          if (len < 20 && $urandom_range(0, 39) == 0) begin
            c = $urandom_range(0, 1) ? CH_DOLLAR : 8'($urandom_range(0, 255));
          end else begin
            c = 8'($urandom_range(CH_PR_LO, CH_PR_HI));
            if (c == CH_DOLLAR || c == CH_STAR) c = 8'h2E;
          end
          push_byte(c);
          sum = sum ^ c;
        end
        push_byte(CH_STAR);
        pick = $urandom_range(0, 9);
        if (pick == 0) sum = sum ^ 8'($urandom_range(1, 255));
        if (pick == 1) begin
          push_byte(8'($urandom_range(0, 255)));
          push_byte(8'($urandom_range(0, 255)));
        end else begin
          push_byte(hex_char(sum[7:4]));
          push_byte(hex_char(sum[3:0]));
        end
        pick = $urandom_range(0, 11);
        if (pick == 0) begin
          push_byte(8'($urandom_range(0, 255)));
        end else begin
          push_byte(CH_CR);
          push_byte(pick == 1 ? 8'($urandom_range(0, 255)) : CH_LF);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender side: offer one transfer, predict its result once it is taken
  // ---------------------------------------------------------------------------
  task automatic offer_item(input framer_item_t it, input logic typed, input res_t typed_want);
    logic [6:0] idx;
    res_t       want;
    idx = it.pick ? pick_read_index() : it.idx;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {1'b0, idx, it.rx};
    do @(posedge clk); while (!in_tready);
    predict_framer(it.cmd, it.rx, idx, want);
    expected_results.push_back(typed ? typed_want : want);
    items_sent++;
  endtask

  task automatic run_traffic();
    while (traffic.size() != 0) offer_item(traffic.pop_front(), 1'b0, NOT_TYPED);
  endtask

  // Drop valid, let every result drain, then write min_length while the block is idle
  task automatic set_min_length(input logic [LEN_W-1:0] v);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frame_min = v;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random back-pressure bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always begin : result_sink
    @(posedge clk);
    if (hold_request) begin
      hold_request = 1'b0;
      out_tready <= 1'b0;
      repeat (LONG_HOLD) @(posedge clk);
      out_tready <= 1'b1;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each result transfer with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[17:0]);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0h", $time, out_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 8'(want.status), 8'(got.status));
        check_field("sentence_length", 8'(want.sentence_length), 8'(got.sentence_length));
        check_field("read_char", want.read_char, got.read_char);
        check_field("tdata padding", 8'h00, 8'(out_tdata[OUT_TDATA_W-1:18]));
        status_seen[got.status]++;
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves on either channel for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    for (i = 0; i < 8; i++) status_seen[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening script at the reset value of min_length
    for (i = 0; i < 27; i++)
      offer_item('{OPENING_SCRIPT[i].cmd, OPENING_SCRIPT[i].rx, OPENING_SCRIPT[i].idx, 1'b0},
                 OPENING_SCRIPT[i].typed, OPENING_SCRIPT[i].want);

    // Lowest limit; ask the receiver for its long hold-off so the block backs up
    set_min_length(7'd0);
    hold_request = 1'b1;
    queue_traffic(PHASE_ITEMS);
    run_traffic();

    // Highest limit: only a full store is accepted
    set_min_length(7'(MAX_SENTENCE));
    queue_traffic(PHASE_ITEMS);
    run_traffic();

    set_min_length(7'($urandom_range(1, MAX_SENTENCE - 1)));
    queue_traffic(PHASE_ITEMS);
    run_traffic();

    // Last part at full rate: no idling on either side
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    set_min_length(MIN_LENGTH_RST);
    queue_traffic(PHASE_ITEMS);
    run_traffic();

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d transfers over four min_length settings, checked %0d results",
             items_sent, results_checked);
    $display("Sentences: %0d accepted, %0d bad checksum, %0d too short, %0d aborted",
             status_seen[ST_OK], status_seen[ST_BADSUM], status_seen[ST_SHORT],
             status_seen[ST_ABORT]);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
